// File: rtl/multitone_signal_generator_core_assert.svh
// assertion macros shared by the multitone generator rtl
`ifndef MULTITONE_SIGNAL_GENERATOR_CORE_ASSERT_SVH
`define MULTITONE_SIGNAL_GENERATOR_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define MTSG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MTSG_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MTSG_ASSERT(lbl, prop, msg)
`define MTSG_ASSERT_ANY(lbl, prop, msg)
`endif
`endif

// File: rtl/mtsg_pkg.sv
// types, constants and sine table function of the multitone generator
package mtsg_pkg;

  localparam int TONES_MAX_DEF   = 2;
  localparam int SINE_DEPTH_DEF  = 1024;
  localparam int PERIODS_MAX_DEF = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int PERIOD_W    = 5;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int PHASE_W     = 32;
  localparam int GAIN_W      = 16;
  localparam int SINE_W      = 16;
  localparam int SAMPLE_W    = 19;
  localparam int INDEX_W     = 32;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  localparam logic [15:0] OUT_GAIN_RESET = 16'h8000;

  localparam longint Q30_ONE  = 64'sd1073741824;
  localparam longint Q30_HALF = 64'sd536870912;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COMP0_STEP,
    REG_COMP0_GAIN,
    REG_COMP1_STEP,
    REG_COMP1_GAIN,
    REG_ACTIVE_TONES,
    REG_SQUARE_MODE,
    REG_NOISE_LEVEL,
    REG_OUTPUT_GAIN
  } cfg_reg_t;

  typedef struct packed {
    logic [PHASE_W-1:0] step0;
    logic [GAIN_W-1:0]  gain0;
    logic [PHASE_W-1:0] step1;
    logic [GAIN_W-1:0]  gain1;
    logic [1:0]         active_tones;
    logic               square_mode;
    logic [GAIN_W-1:0]  noise_level;
    logic [GAIN_W-1:0]  output_gain;
  } cfg_t;

  typedef struct packed {
    logic                push;
    logic [PERIOD_W-1:0] periods;
  } queue_wr_t;

  typedef struct packed {
    logic                avail;
    logic [PERIOD_W-1:0] periods;
  } queue_head_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_ADVANCE,
    B_ADDR,
    B_LOOK,
    B_MUL,
    B_ACC,
    B_MIX,
    B_SUM,
    B_SCALE,
    B_ROUND,
    B_EMIT
  } back_state_t;

  // odd polynomial for sin(pi/2 x), x in q30, scaled to q15 and clamped
  function automatic logic [14:0] quarter_entry(longint x);
    longint x2;
    longint p;
    longint s;
    longint v;
    x2 = (x * x) / Q30_ONE;
    p  = 64'sd172272;
    p  = -64'sd5026995 + (p * x2) / Q30_ONE;
    p  = 64'sd85569306 + (p * x2) / Q30_ONE;
    p  = -64'sd693598668 + (p * x2) / Q30_ONE;
    p  = 64'sd1686629713 + (p * x2) / Q30_ONE;
    s  = (p * x) / Q30_ONE;
    v  = (s * 64'sd32767 + Q30_HALF) / Q30_ONE;
    if (v < 0) v = 0;
    if (v > 64'sd32767) v = 64'sd32767;
    return v[14:0];
  endfunction

endpackage

// File: rtl/mtsg_in_if.sv
// input channel carrying the elapsed period count
interface mtsg_in_if import mtsg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PERIOD_W-1:0] elapsed_periods;

  modport source (output valid, output elapsed_periods, input ready);
  modport sink (input valid, input elapsed_periods, output ready);
endinterface

// File: rtl/mtsg_out_if.sv
// output channel carrying generated samples
interface mtsg_out_if import mtsg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic [INDEX_W-1:0]         sample_index;
  logic                       last_sample;

  modport source (output valid, output sample_value, output sample_index,
                  output last_sample, input ready);
  modport sink (input valid, input sample_value, input sample_index,
                input last_sample, output ready);
endinterface

// File: rtl/mtsg_front.sv
// front end: takes input transactions, drops empty ones, caps the period count
module mtsg_front import mtsg_pkg::*; #(
  parameter int MAX_PERIODS_PER_ITEM = PERIODS_MAX_DEF
) (
  mtsg_in_if.sink   periods,
  input  logic      full,
  output queue_wr_t wr
);

  localparam logic [6:0] MaxPeriods = 7'(MAX_PERIODS_PER_ITEM);

  logic                accept;
  logic                over;
  logic [PERIOD_W-1:0] capped;

  assign periods.ready = !full;
  assign accept        = periods.valid && periods.ready;
  assign over          = {2'b00, periods.elapsed_periods} > MaxPeriods;
  assign capped        = over ? MaxPeriods[PERIOD_W-1:0] : periods.elapsed_periods;

  assign wr.push    = accept && (periods.elapsed_periods != '0);
  assign wr.periods = capped;

endmodule

// File: rtl/mtsg_queue.sv
// short queue of period counts between front and back end
module mtsg_queue import mtsg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  queue_wr_t   wr,
  input  logic        pop,
  output logic        full,
  output queue_head_t head
);
`include "multitone_signal_generator_core_assert.svh"

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic [PERIOD_W-1:0] slots [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;

  assign full         = count == CntW'(QUEUE_DEPTH);
  assign head.avail   = count != '0;
  assign head.periods = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (wr.push && !pop) count <= count + 1'b1;
      else if (!wr.push && pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.push) slots[wr_ptr] <= wr.periods;
  end

  `MTSG_ASSERT(a_no_push_full, full |-> !wr.push, "push into full queue")
  `MTSG_ASSERT(a_no_pop_empty, (count == '0) |-> !pop, "pop from empty queue")
  `MTSG_ASSERT_ANY(a_reset_empty, rst |=> (count == '0), "queue not empty after reset")

endmodule

// File: rtl/mtsg_sine_rom.sv
// quarter-wave sine lookup, two register stages from phase to signed q15
module mtsg_sine_rom import mtsg_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic [PHASE_W-1:0]       phase,
  output logic signed [SINE_W-1:0] sine
);

  localparam int Q  = SINE_TABLE_DEPTH / 4;
  localparam int QB = $clog2(Q + 1);
  localparam logic [QB-1:0] QVal = QB'(Q);

  logic [14:0]      rom [Q + 1];
  logic [30+QB-1:0] scaled;
  logic [QB-1:0]    idx;
  logic [QB-1:0]    addr;
  logic             neg;

  for (genvar g = 0; g <= Q; g++) begin : g_rom
    localparam longint Xg = (longint'(g) * Q30_ONE) / Q;
    assign rom[g] = quarter_entry(Xg);
  end

  assign scaled = {{QB{1'b0}}, phase[29:0]} * {{30{1'b0}}, QVal};
  assign idx    = scaled[30+QB-1:30];

  always_ff @(posedge clk) begin
    addr <= phase[30] ? QVal - idx : idx;
    neg  <= phase[31];
    sine <= neg ? -$signed({1'b0, rom[addr]}) : $signed({1'b0, rom[addr]});
  end

endmodule

// File: rtl/mtsg_back.sv
// back end: per period sequencer for phases, tone sum, noise, gain and output
module mtsg_back import mtsg_pkg::*; #(
  parameter int MAX_TONES        = TONES_MAX_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  queue_head_t head,
  output logic        pop,
  mtsg_out_if.source  samples
);
`include "multitone_signal_generator_core_assert.svh"

  localparam int TW = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
  localparam logic [2:0] TonesTop = 3'(MAX_TONES);
  localparam logic signed [33:0] SqPos = 34'sd1073741824;
  localparam logic signed [33:0] SqNeg = -34'sd1073741824;
  localparam logic signed [51:0] RoundBias = 52'sd1073741824;
  localparam logic signed [20:0] OutMax = 21'sd262143;
  localparam logic signed [20:0] OutMin = -21'sd262144;

  back_state_t state;
  back_state_t state_next;
  logic        load;

  logic [PHASE_W-1:0]  phase [MAX_TONES];
  logic [PHASE_W-1:0]  step_of [MAX_TONES];
  logic [15:0]         lfsr;
  logic [15:0]         lfsr_next;
  logic [INDEX_W-1:0]  sample_counter;
  logic [PERIOD_W-1:0] remaining;
  logic [TW-1:0]       tone;
  logic [TW-1:0]       last_tone;
  logic [2:0]          act;
  logic [GAIN_W-1:0]   gain_sel;

  logic signed [SINE_W-1:0]   sine;
  logic signed [32:0]         prod;
  logic signed [33:0]         acc;
  logic signed [32:0]         noise;
  logic signed [34:0]         total;
  logic signed [51:0]         scaled;
  logic signed [51:0]         biased;
  logic signed [20:0]         rounded;
  logic signed [SAMPLE_W-1:0] sample;

  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_value;
  logic [INDEX_W-1:0]         out_index;
  logic                       out_last;

  for (genvar g = 0; g < MAX_TONES; g++) begin : g_step
    assign step_of[g] = (g % 2 == 0) ? cfg.step0 : cfg.step1;
  end

  mtsg_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_rom (
    .clk  (clk),
    .phase(phase[tone]),
    .sine (sine)
  );

  assign act      = {1'b0, cfg.active_tones};
  assign gain_sel = (tone == '0) ? cfg.gain0 : cfg.gain1;

  always_comb begin
    if (act <= 3'd1) last_tone = '0;
    else if (act >= TonesTop) last_tone = TW'(MAX_TONES - 1);
    else last_tone = TW'(act - 3'd1);
  end

  assign lfsr_next = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
  assign biased    = scaled + RoundBias;
  assign rounded   = $signed(biased[51:31]);

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load       = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (head.avail) begin
          pop        = 1'b1;
          state_next = B_ADVANCE;
        end
      end
      B_ADVANCE: state_next = B_ADDR;
      B_ADDR:    state_next = B_LOOK;
      B_LOOK:    state_next = B_MUL;
      B_MUL:     state_next = B_ACC;
      B_ACC:     state_next = (tone == last_tone) ? B_MIX : B_ADDR;
      B_MIX:     state_next = B_SUM;
      B_SUM:     state_next = B_SCALE;
      B_SCALE:   state_next = B_ROUND;
      B_ROUND:   state_next = B_EMIT;
      B_EMIT: begin
        if (!out_valid || samples.ready) begin
          load       = 1'b1;
          state_next = (remaining == PERIOD_W'(1)) ? B_IDLE : B_ADVANCE;
        end
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < MAX_TONES; t++) phase[t] <= '0;
      lfsr           <= LFSR_SEED;
      sample_counter <= '0;
      remaining      <= '0;
      tone           <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (samples.ready) out_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (pop) remaining <= head.periods;
        end
        B_ADVANCE: begin
          for (int t = 0; t < MAX_TONES; t++) phase[t] <= phase[t] + step_of[t];
          lfsr <= lfsr_next;
          tone <= '0;
        end
        B_ACC: begin
          if (tone != last_tone) tone <= tone + 1'b1;
        end
        B_EMIT: begin
          if (load) begin
            sample_counter <= sample_counter + 1'b1;
            remaining      <= remaining - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      B_ADVANCE: acc <= '0;
      B_MUL:     prod <= sine * $signed({1'b0, gain_sel});
      B_ACC:     acc <= acc + 34'(prod);
      B_MIX: begin
        if (cfg.square_mode) acc <= acc[33] ? SqNeg : SqPos;
        noise <= $signed({~lfsr[15], lfsr[14:0]}) * $signed({1'b0, cfg.noise_level});
      end
      B_SUM:   total <= 35'(acc) + 35'(noise);
      B_SCALE: scaled <= total * $signed({1'b0, cfg.output_gain});
      B_ROUND: begin
        if (rounded > OutMax) sample <= OutMax[SAMPLE_W-1:0];
        else if (rounded < OutMin) sample <= OutMin[SAMPLE_W-1:0];
        else sample <= rounded[SAMPLE_W-1:0];
      end
      B_EMIT: begin
        if (load) begin
          out_value <= sample;
          out_index <= sample_counter + 1'b1;
          out_last  <= remaining == PERIOD_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign samples.valid        = out_valid;
  assign samples.sample_value = out_value;
  assign samples.sample_index = out_index;
  assign samples.last_sample  = out_last;

  `MTSG_ASSERT(a_busy_has_work, (state != B_IDLE) |-> (remaining != '0), "busy with no work")
  `MTSG_ASSERT(a_counter_on_load, !load |=> $stable(sample_counter), "counter moved without load")
  `MTSG_ASSERT(a_tone_in_range, (state == B_ACC) |-> (tone <= last_tone), "tone past last tone")

endmodule

// File: rtl/multitone_signal_generator_core.sv
// top level of the multitone test-signal generator with configuration registers
//
//   channel   role    payload
//   periods   sink    elapsed_periods
//   samples   source  sample_value, sample_index, last_sample
//   cfg_*     write   cfg_index selects the register, cfg_data is the value
//
// each period runs an advance step, address, lookup, multiply and accumulate per active tone,
// then mix, sum, scale, round and emit: the back-end sequencer runs the tones one at a time
// through the sine lookup and multiplier
// up to four items wait in the queue while the back end works
// a sample not taken stalls the sequencer only at its output register
// reset clears phases and sample counter, seeds the noise register, loads register defaults
module multitone_signal_generator_core import mtsg_pkg::*; #(
  parameter int MAX_TONES            = TONES_MAX_DEF,
  parameter int SINE_TABLE_DEPTH     = SINE_DEPTH_DEF,
  parameter int MAX_PERIODS_PER_ITEM = PERIODS_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  mtsg_in_if.sink                periods,
  mtsg_out_if.source             samples,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t        cfg;
  queue_wr_t   wr;
  queue_head_t head;
  logic        full;
  logic        pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step0        <= '0;
      cfg.gain0        <= '0;
      cfg.step1        <= '0;
      cfg.gain1        <= '0;
      cfg.active_tones <= 2'd1;
      cfg.square_mode  <= 1'b0;
      cfg.noise_level  <= '0;
      cfg.output_gain  <= OUT_GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COMP0_STEP:   cfg.step0        <= cfg_data;
        REG_COMP0_GAIN:   cfg.gain0        <= cfg_data[GAIN_W-1:0];
        REG_COMP1_STEP:   cfg.step1        <= cfg_data;
        REG_COMP1_GAIN:   cfg.gain1        <= cfg_data[GAIN_W-1:0];
        REG_ACTIVE_TONES: cfg.active_tones <= cfg_data[1:0];
        REG_SQUARE_MODE:  cfg.square_mode  <= cfg_data[0];
        REG_NOISE_LEVEL:  cfg.noise_level  <= cfg_data[GAIN_W-1:0];
        REG_OUTPUT_GAIN:  cfg.output_gain  <= cfg_data[GAIN_W-1:0];
      endcase
    end
  end

  mtsg_front #(
    .MAX_PERIODS_PER_ITEM(MAX_PERIODS_PER_ITEM)
  ) u_front (
    .periods(periods),
    .full   (full),
    .wr     (wr)
  );

  mtsg_queue u_queue (
    .clk (clk),
    .rst (rst),
    .wr  (wr),
    .pop (pop),
    .full(full),
    .head(head)
  );

  mtsg_back #(
    .MAX_TONES       (MAX_TONES),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (head),
    .pop    (pop),
    .samples(samples)
  );

endmodule
